// File: rtl/core/atbl_pkg.sv
// Shared types and codes for the array table engine.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package atbl_pkg;

    localparam int ELEM_W   = 32;
    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [KIND_W-1:0]        t_kind;

    // command kinds
    localparam t_kind KIND_LOAD   = 3'd0;
    localparam t_kind KIND_DELETE = 3'd1;
    localparam t_kind KIND_SEARCH = 3'd2;
    localparam t_kind KIND_READ   = 3'd3;
    localparam t_kind KIND_SORT   = 3'd4;

    // result status codes
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_BADPOS   = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

endpackage

`default_nettype wire

// File: rtl/core/atbl_mem.sv
// Element store: one write port, one read port with registered read data.
// Uses atbl_pkg for the element type.
`timescale 1ns / 1ps
`default_nettype none

module atbl_mem #(
    parameter int DEPTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire atbl_pkg::t_elem            i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output atbl_pkg::t_elem                 o_rdata
);

    atbl_pkg::t_elem r_mem [DEPTH];
    atbl_pkg::t_elem r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/atbl_cmp.sv
// Shared compare unit: equality and signed greater-than on two elements.
// Uses atbl_pkg for the element type.
`timescale 1ns / 1ps
`default_nettype none

module atbl_cmp (
    input  wire atbl_pkg::t_elem i_a,
    input  wire atbl_pkg::t_elem i_b,
    output logic                 o_eq,
    output logic                 o_gt
);

    assign o_eq = (i_a == i_b);
    assign o_gt = (i_a > i_b);

endmodule

`default_nettype wire

// File: rtl/core/array_table_engine_top.sv
// Array table engine top: command sequencer, output register, store and compare unit.
// Depends on atbl_pkg, atbl_mem and atbl_cmp.
//
//  channel  dir  tdata (low bit up)                          tuser  tlast
//  s_axis   in   value[31:0] position[37:32] restart[38] pad kind   -
//  m_axis   out  status[1:0] found_position[7:2] element     -      last
//
// One command at a time; s_axis_tready is high only while the sequencer is idle.
// Sort runs bubble passes with lim = n-1 (n = count) down to 1, with an early exit
// on a pass without swaps; unknown kinds are dropped without a result.
// A result waits until the output register frees up.
// All walks go through the single read port of the store.
// Reset empties the table (count 0); stored elements are not cleared.
// The output register lets the next command in while a result waits on m_axis.
`timescale 1ns / 1ps
`default_nettype none

module array_table_engine_top #(
    parameter int DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // value, position, restart, zero pad
    input  wire logic [2:0]  s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // status, found_position, element
    output logic             m_axis_tlast
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = CW + atbl_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMIT,
        S_RD_WAIT,
        S_RD_GET,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SRCH_END,
        S_DEL_RD,
        S_DEL_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SORT_P0,
        S_SORT_LA,
        S_SORT_CMP,
        S_SORT_END
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_lim;
    atbl_pkg::t_elem   r_val;
    atbl_pkg::t_elem   r_a;
    logic              r_swap;
    logic              r_pend;
    atbl_pkg::t_pos    r_pend_pos;
    atbl_pkg::t_pos    r_hit;
    atbl_pkg::t_status r_res_status;
    atbl_pkg::t_pos    r_res_pos;
    atbl_pkg::t_elem   r_res_elem;

    logic              r_out_valid;
    atbl_pkg::t_status r_out_status;
    atbl_pkg::t_pos    r_out_pos;
    atbl_pkg::t_elem   r_out_elem;
    logic              r_out_last;

    // input beat fields
    atbl_pkg::t_kind   in_kind;
    atbl_pkg::t_elem   in_value;
    atbl_pkg::t_pos    in_pos;
    logic              in_restart;

    logic              out_free;
    logic              full;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     idx_dec;
    logic [CMPW-1:0]   pos_ext;
    logic              pos_bad;
    logic              sorting;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    atbl_pkg::t_elem   mem_wdata;
    logic [AW-1:0]     mem_raddr;
    atbl_pkg::t_elem   mem_rdata;
    atbl_pkg::t_elem   cmp_a;
    logic              cmp_eq;
    logic              cmp_gt;

    assign in_kind    = s_axis_tuser;
    assign in_value   = s_axis_tdata[31:0];
    assign in_pos     = s_axis_tdata[37:32];
    assign in_restart = s_axis_tdata[38];

    assign out_free = !r_out_valid || m_axis_tready;
    assign full     = (r_count == CW'(DEPTH));
    assign idx_inc  = r_idx + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign pos_ext  = CMPW'(in_pos);
    assign pos_bad  = (in_pos == '0) || (pos_ext > CMPW'(r_count));
    assign sorting  = (r_state == S_SORT_LA) || (r_state == S_SORT_CMP);

    assign cmp_a = sorting ? r_a : r_val;

    // store port control; the sort compare stage reads one entry ahead
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = (r_state == S_SORT_CMP) ? idx_inc[AW-1:0] : r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_we    = s_axis_tvalid && (in_kind == atbl_pkg::KIND_LOAD)
                            && (in_restart || !full);
                mem_waddr = in_restart ? '0 : r_count[AW-1:0];
                mem_wdata = in_value;
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_SORT_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = idx_dec[AW-1:0];
                mem_wdata = cmp_gt ? mem_rdata : r_a;
            end
            S_SORT_END: begin
                mem_we    = 1'b1;
                mem_waddr = r_lim[AW-1:0];
                mem_wdata = r_a;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_swap      <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_val        <= in_value;
                        r_res_status <= atbl_pkg::ST_OK;
                        r_res_pos    <= '0;
                        r_res_elem   <= '0;
                        r_idx        <= '0;
                        unique case (in_kind)
                            atbl_pkg::KIND_LOAD: begin
                                if (in_restart) begin
                                    r_count <= CW'(1);
                                end else if (full) begin
                                    r_res_status <= atbl_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_EMIT;
                            end
                            atbl_pkg::KIND_DELETE: begin
                                r_state <= S_DEL_RD;
                            end
                            atbl_pkg::KIND_SEARCH: begin
                                r_pend  <= 1'b0;
                                r_state <= S_SRCH_RD;
                            end
                            atbl_pkg::KIND_READ: begin
                                if (pos_bad) begin
                                    r_res_status <= atbl_pkg::ST_BADPOS;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_idx   <= CW'(pos_ext - CMPW'(1));
                                    r_state <= S_RD_WAIT;
                                end
                            end
                            atbl_pkg::KIND_SORT: begin
                                r_lim <= r_count - CW'(1);
                                if (r_count < CW'(2)) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_SORT_P0;
                                end
                            end
                            default: begin
                                // unknown kinds are dropped without a result
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_pos    <= r_res_pos;
                        r_out_elem   <= r_res_elem;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_GET;
                end
                S_RD_GET: begin
                    r_res_elem <= mem_rdata;
                    r_state    <= S_EMIT;
                end
                S_SRCH_RD: begin
                    r_state <= (r_idx == r_count) ? S_SRCH_END : S_SRCH_CMP;
                end
                S_SRCH_CMP: begin
                    // a hit is held back until the next one shows it is not the last
                    if (!cmp_eq) begin
                        r_idx   <= idx_inc;
                        r_state <= S_SRCH_RD;
                    end else if (!r_pend || out_free) begin
                        if (r_pend) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= atbl_pkg::ST_OK;
                            r_out_pos    <= r_pend_pos;
                            r_out_elem   <= '0;
                            r_out_last   <= 1'b0;
                        end
                        r_pend     <= 1'b1;
                        r_pend_pos <= atbl_pkg::POS_W'(idx_inc);
                        r_idx      <= idx_inc;
                        r_state    <= S_SRCH_RD;
                    end
                end
                S_SRCH_END: begin
                    r_res_status <= r_pend ? atbl_pkg::ST_OK : atbl_pkg::ST_NOTFOUND;
                    r_res_pos    <= r_pend ? r_pend_pos : '0;
                    r_state      <= S_EMIT;
                end
                S_DEL_RD: begin
                    if (r_idx == r_count) begin
                        r_res_status <= atbl_pkg::ST_NOTFOUND;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_DEL_CMP;
                    end
                end
                S_DEL_CMP: begin
                    r_idx <= idx_inc;
                    if (cmp_eq) begin
                        r_hit   <= atbl_pkg::POS_W'(idx_inc);
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_DEL_RD;
                    end
                end
                S_SHIFT_RD: begin
                    if (r_idx == r_count) begin
                        r_count   <= r_count - CW'(1);
                        r_res_pos <= r_hit;
                        r_state   <= S_EMIT;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= idx_inc;
                    r_state <= S_SHIFT_RD;
                end
                S_SORT_P0: begin
                    r_idx   <= CW'(1);
                    r_swap  <= 1'b0;
                    r_state <= S_SORT_LA;
                end
                S_SORT_LA: begin
                    r_a     <= mem_rdata;
                    r_state <= S_SORT_CMP;
                end
                S_SORT_CMP: begin
                    // carry the larger element up the pass, write back the smaller
                    if (cmp_gt) begin
                        r_swap <= 1'b1;
                    end else begin
                        r_a <= mem_rdata;
                    end
                    if (r_idx == r_lim) begin
                        r_state <= S_SORT_END;
                    end else begin
                        r_idx <= idx_inc;
                    end
                end
                S_SORT_END: begin
                    if (!r_swap || (r_lim == CW'(1))) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_lim   <= r_lim - CW'(1);
                        r_idx   <= '0;
                        r_state <= S_SORT_P0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    atbl_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    atbl_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (mem_rdata),
        .o_eq (cmp_eq),
        .o_gt (cmp_gt)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_elem, r_out_pos, r_out_status};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
